/* sv/scr_pkg.sv */
// scr_pkg: shared types and constants of the search result cache.
// Slot layout, write-port bundle, opcodes and register indexes.
// No dependencies.
`default_nettype none

package scr_pkg;

	// entry count must be a power of two: the slot index is the low key bits
	localparam int unsigned TABLE_ENTRIES = 65536;
	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned MOVE_W  = 32;
	localparam int unsigned FLAG_W  = 8;
	localparam int unsigned DEPTH_W = 16;
	localparam int unsigned SCORE_W = 16;

	typedef logic [IDX_W-1:0] slot_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [MOVE_W-1:0]         move;
		logic [FLAG_W-1:0]         flag;
		logic signed [DEPTH_W-1:0] depth;
		logic signed [SCORE_W-1:0] score;
	} slot_entry_t;

	typedef struct packed {
		logic        en;
		slot_idx_t   idx;
		slot_entry_t data;
	} slot_wr_t;

	localparam slot_entry_t SLOT_RESET = '{
		key:   '0,
		move:  '0,
		flag:  '0,
		depth: -16'sd1,
		score: '0
	};

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_PROBE = 1'b1;

	localparam logic REG_OLD_MARK_MASK = 1'b0;
	localparam logic REG_MISS_CODE     = 1'b1;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [FLAG_W-1:0] OLD_MARK_MASK_RESET = 8'd127;
	localparam logic [FLAG_W-1:0] MISS_CODE_RESET     = 8'd0;

endpackage

`default_nettype wire

/* sv/scr_slot_ram.sv */
// scr_slot_ram: slot memory, one write and one registered read port.
// Read data holds until the next enabled read.
// Depends on scr_pkg.
`default_nettype none

module scr_slot_ram (
	input  wire                  clk,
	input  scr_pkg::slot_wr_t    wr,
	input  wire                  rd_en,
	input  scr_pkg::slot_idx_t   rd_idx,
	output scr_pkg::slot_entry_t rd_data
);
	import scr_pkg::*;

	slot_entry_t mem [TABLE_ENTRIES];
	slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* sv/scr_cfg_regs.sv */
// scr_cfg_regs: APB register file, old-mark mask and miss code.
// Writes complete in the access phase; pready is tied high.
// Depends on scr_pkg.
`default_nettype none

module scr_cfg_regs (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [scr_pkg::PADDR_W-1:0]  paddr,
	input  wire [scr_pkg::PDATA_W-1:0]  pwdata,
	output logic [scr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [scr_pkg::FLAG_W-1:0]  old_mark_mask,
	output logic [scr_pkg::FLAG_W-1:0]  miss_code
);
	import scr_pkg::*;

	logic [FLAG_W-1:0] old_mark_mask_q;
	logic [FLAG_W-1:0] miss_code_q;
	logic              reg_sel;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_mark_mask_q <= OLD_MARK_MASK_RESET;
			miss_code_q     <= MISS_CODE_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_OLD_MARK_MASK: old_mark_mask_q <= pwdata[FLAG_W-1:0];
				REG_MISS_CODE:     miss_code_q     <= pwdata[FLAG_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_OLD_MARK_MASK: prdata = PDATA_W'(old_mark_mask_q);
			REG_MISS_CODE:     prdata = PDATA_W'(miss_code_q);
			default:           prdata = '0;
		endcase
	end

	assign old_mark_mask = old_mark_mask_q;
	assign miss_code     = miss_code_q;

endmodule

`default_nettype wire

/* sv/scr_slot_pipe.sv */
// scr_slot_pipe: read-modify-write stage over the slot memory.
// Forwards the last write, decides replacement and probe hits, holds the response.
// Depends on scr_pkg.
`default_nettype none

module scr_slot_pipe (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  wire [0:0]                    opcode,
	input  wire [scr_pkg::KEY_W-1:0]     position_key,
	input  wire [scr_pkg::MOVE_W-1:0]    best_move,
	input  wire signed [scr_pkg::DEPTH_W-1:0] search_depth,
	input  wire [scr_pkg::FLAG_W-1:0]    bound_flag,
	input  wire signed [scr_pkg::SCORE_W-1:0] score_value,
	input  scr_pkg::slot_entry_t         rd_data,
	input  wire [scr_pkg::FLAG_W-1:0]    old_mark_mask,
	input  wire [scr_pkg::FLAG_W-1:0]    miss_code,
	input  wire                          rsp_stall,
	output scr_pkg::slot_wr_t            wr,
	output logic                         hold,
	output logic                         rsp_valid,
	output logic [scr_pkg::FLAG_W-1:0]   probe_flag
);
	import scr_pkg::*;

	logic                      valid_s1;
	logic                      op_s1;
	logic [KEY_W-1:0]          key_s1;
	logic [MOVE_W-1:0]         move_s1;
	logic signed [DEPTH_W-1:0] depth_s1;
	logic [FLAG_W-1:0]         flag_s1;
	logic signed [SCORE_W-1:0] score_s1;

	logic                      fwd_valid_q;
	slot_idx_t                 fwd_idx_q;
	slot_entry_t               fwd_data_q;

	logic                      rsp_valid_q;
	logic [FLAG_W-1:0]         probe_flag_q;

	slot_idx_t                 idx_s1;
	slot_entry_t               cur;
	slot_entry_t               next_entry;
	logic                      wins;
	logic                      hit;
	logic                      go;

	assign idx_s1 = key_s1[IDX_W-1:0];
	assign cur    = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : rd_data;

	assign wins = (flag_s1 > cur.flag) || (flag_s1 == cur.flag && depth_s1 >= cur.depth);
	assign hit  = (cur.key == key_s1) && (cur.depth >= depth_s1);

	assign hold = valid_s1 && op_s1 == OP_PROBE && rsp_valid_q && rsp_stall;
	assign go   = valid_s1 && !hold;

	always_comb begin
		next_entry = cur;
		if (wins) begin
			next_entry.key   = key_s1;
			next_entry.move  = move_s1;
			next_entry.flag  = flag_s1;
			next_entry.depth = depth_s1;
			next_entry.score = score_s1;
		end else begin
			next_entry.flag = cur.flag & old_mark_mask;
		end
	end

	assign wr.en   = go && op_s1 == OP_STORE;
	assign wr.idx  = idx_s1;
	assign wr.data = next_entry;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode[0];
			key_s1   <= position_key;
			move_s1  <= best_move;
			depth_s1 <= search_depth;
			flag_s1  <= bound_flag;
			score_s1 <= score_value;
		end
		if (wr.en) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= next_entry;
		end
		if (go && op_s1 == OP_PROBE) begin
			probe_flag_q <= hit ? cur.flag : miss_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (wr.en) begin
				fwd_valid_q <= 1'b1;
			end
			if (go && op_s1 == OP_PROBE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign probe_flag = probe_flag_q;

endmodule

`default_nettype wire

/* sv/search_result_cache.sv */
// search_result_cache: direct-mapped table of search results, flag- then depth-preferred replacement.
// Top level: slot clearing sequencer, slot memory, register file, update stage.
// Depends on scr_pkg, scr_slot_ram, scr_cfg_regs, scr_slot_pipe.
//
//   port group  dir  handshake           contents
//   req_*       in   req_valid/req_stall opcode, position_key, best_move, search_depth,
//                                        bound_flag, score_value
//   rsp_*       out  rsp_valid/rsp_stall probe_flag (probes only)
//   APB         in   psel/penable/pready old_mark_mask at 0x0, miss_code at 0x4
//
// One request per cycle while req_stall is low; a request's slot is read when accepted
// and a store writes it back in the next cycle, the last write forwarded to the following
// request. A probe response enters the rsp register once no waiting response stalls it.
// After reset, the slot memory is cleared one entry a cycle, all 65536 entries; req_stall
// is high during that time. A waiting response blocks a probe behind it.
`default_nettype none

module search_result_cache (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  wire [0:0]                    opcode,
	input  wire [scr_pkg::KEY_W-1:0]     position_key,
	input  wire [scr_pkg::MOVE_W-1:0]    best_move,
	input  wire signed [scr_pkg::DEPTH_W-1:0] search_depth,
	input  wire [scr_pkg::FLAG_W-1:0]    bound_flag,
	input  wire signed [scr_pkg::SCORE_W-1:0] score_value,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output logic [scr_pkg::FLAG_W-1:0]   probe_flag,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [scr_pkg::PADDR_W-1:0]   paddr,
	input  wire [scr_pkg::PDATA_W-1:0]   pwdata,
	output logic [scr_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import scr_pkg::*;

	logic              clearing_q;
	slot_idx_t         clr_idx_q;
	logic              accept;
	logic              hold;
	slot_wr_t          pipe_wr;
	slot_wr_t          ram_wr;
	slot_entry_t       rd_data;
	logic [FLAG_W-1:0] old_mark_mask;
	logic [FLAG_W-1:0] miss_code;

	assign req_stall = clearing_q || hold;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_comb begin
		if (clearing_q) begin
			ram_wr.en   = 1'b1;
			ram_wr.idx  = clr_idx_q;
			ram_wr.data = SLOT_RESET;
		end else begin
			ram_wr = pipe_wr;
		end
	end

	scr_slot_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (accept),
		.rd_idx  (position_key[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	scr_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.old_mark_mask (old_mark_mask),
		.miss_code     (miss_code)
	);

	scr_slot_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.opcode        (opcode),
		.position_key  (position_key),
		.best_move     (best_move),
		.search_depth  (search_depth),
		.bound_flag    (bound_flag),
		.score_value   (score_value),
		.rd_data       (rd_data),
		.old_mark_mask (old_mark_mask),
		.miss_code     (miss_code),
		.rsp_stall     (rsp_stall),
		.wr            (pipe_wr),
		.hold          (hold),
		.rsp_valid     (rsp_valid),
		.probe_flag    (probe_flag)
	);

endmodule

`default_nettype wire
